/* rtl/utf8_replacing_decoder_defines.svh */
// Assertion macros used by the checker module.
`ifndef UTF8_REPLACING_DECODER_DEFINES_SVH
`define UTF8_REPLACING_DECODER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define U8RD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("u8rd assertion failed");

// Next-cycle implication, off while reset is asserted.
`define U8RD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("u8rd assertion failed");

// Next-cycle implication, checked during reset too.
`define U8RD_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("u8rd assertion failed");

`endif

/* rtl/u8rd_pkg.sv */
package u8rd_pkg;

    localparam int JOB_BYTES = 6;
    localparam int QDEPTH    = 2;

    localparam logic [7:0] RPL_B0   = 8'hEF;
    localparam logic [7:0] RPL_B1   = 8'hBF;
    localparam logic [7:0] RPL_B2   = 8'hBD;
    localparam logic [7:0] CONT_LO  = 8'h80;
    localparam logic [7:0] CONT_HI  = 8'hBF;
    localparam logic [7:0] E0_LO    = 8'hA0;
    localparam logic [7:0] ED_HI    = 8'h9F;
    localparam logic [7:0] F0_LO    = 8'h90;
    localparam logic [7:0] F4_HI    = 8'h8F;
    localparam logic [20:0] BOM_CP  = 21'h00FEFF;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic CFG_FATAL    = 1'b0;
    localparam logic CFG_KEEP_BOM = 1'b1;

    // One decoded burst: bytes[0] goes out first.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [2:0]                cnt;
        logic                      err;
    } job_t;

endpackage

/* rtl/u8rd_front.sv */
module u8rd_front import u8rd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic       cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  logic [7:0] s_byte,
    input  logic       q_full,
    output logic       push,
    output job_t       push_job
);

    logic        fatal_reg, keep_bom_reg;
    logic [1:0]  need_reg, need_next;
    logic [7:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [20:0] acc_reg, acc_next;
    logic        bom_reg, bom_next;

    logic        fire;
    logic        l_start, l_ascii, l_bad;
    logic [1:0]  l_need;
    logic [7:0]  l_lo, l_hi;
    logic [20:0] l_bits;
    logic [2:0][7:0] lb;
    logic [1:0]  ln;
    logic        l_err;
    logic [20:0] cp;
    logic        bom_drop;

    assign s_ready = !q_full;
    assign fire    = s_valid && s_ready;
    assign cp      = {acc_reg[14:0], s_byte[5:0]};

    always_comb begin
        l_start = 1'b0;
        l_ascii = 1'b0;
        l_bad   = 1'b0;
        l_need  = 2'd0;
        l_lo    = CONT_LO;
        l_hi    = CONT_HI;
        l_bits  = '0;
        priority if (s_byte < 8'h80) begin
            l_ascii = 1'b1;
        end else if (s_byte >= 8'hC2 && s_byte <= 8'hDF) begin
            l_start = 1'b1; l_need = 2'd1; l_bits = {16'd0, s_byte[4:0]};
        end else if (s_byte == 8'hE0) begin
            l_start = 1'b1; l_need = 2'd2; l_lo = E0_LO; l_bits = {17'd0, s_byte[3:0]};
        end else if (s_byte == 8'hED) begin
            l_start = 1'b1; l_need = 2'd2; l_hi = ED_HI; l_bits = {17'd0, s_byte[3:0]};
        end else if (s_byte >= 8'hE1 && s_byte <= 8'hEF) begin
            l_start = 1'b1; l_need = 2'd2; l_bits = {17'd0, s_byte[3:0]};
        end else if (s_byte == 8'hF0) begin
            l_start = 1'b1; l_need = 2'd3; l_lo = F0_LO; l_bits = {18'd0, s_byte[2:0]};
        end else if (s_byte == 8'hF4) begin
            l_start = 1'b1; l_need = 2'd3; l_hi = F4_HI; l_bits = {18'd0, s_byte[2:0]};
        end else if (s_byte >= 8'hF1 && s_byte <= 8'hF3) begin
            l_start = 1'b1; l_need = 2'd3; l_bits = {18'd0, s_byte[2:0]};
        end else begin
            l_bad = 1'b1;
        end

        lb    = '0;
        ln    = 2'd0;
        l_err = 1'b0;
        if (l_ascii) begin
            lb[0] = s_byte;
            ln    = 2'd1;
        end else if (l_bad && fatal_reg) begin
            ln    = 2'd1;
            l_err = 1'b1;
        end else if (l_bad) begin
            lb = {RPL_B2, RPL_B1, RPL_B0};
            ln = 2'd3;
        end
    end

    always_comb begin
        need_next = need_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        acc_next  = acc_reg;
        bom_next  = bom_reg;
        push      = 1'b0;
        push_job  = '0;
        bom_drop  = 1'b0;
        if (fire) begin
            if (s_kind == KIND_END) begin
                if (need_reg != 2'd0) begin
                    push = 1'b1;
                    push_job.cnt = fatal_reg ? 3'd1 : 3'd3;
                    push_job.err = fatal_reg;
                    if (!fatal_reg) begin
                        push_job.bytes[0] = RPL_B0;
                        push_job.bytes[1] = RPL_B1;
                        push_job.bytes[2] = RPL_B2;
                    end
                end
                need_next = 2'd0;
                lo_next   = CONT_LO;
                hi_next   = CONT_HI;
                acc_next  = '0;
                bom_next  = 1'b0;
            end else if (need_reg == 2'd0 ||
                         ((s_byte < lo_reg || s_byte > hi_reg) && !fatal_reg)) begin
                if (need_reg == 2'd0) begin
                    push_job.bytes[2:0] = lb;
                    push_job.cnt        = {1'b0, ln};
                    push_job.err        = l_err;
                    push                = (ln != 2'd0);
                end else begin
                    push_job.bytes[0]   = RPL_B0;
                    push_job.bytes[1]   = RPL_B1;
                    push_job.bytes[2]   = RPL_B2;
                    push_job.bytes[5:3] = lb;
                    push_job.cnt        = 3'd3 + {1'b0, ln};
                    push_job.err        = l_err;
                    push                = 1'b1;
                    bom_next            = 1'b1;
                end
                need_next = 2'd0;
                lo_next   = CONT_LO;
                hi_next   = CONT_HI;
                acc_next  = '0;
                if (l_start) begin
                    need_next = l_need;
                    lo_next   = l_lo;
                    hi_next   = l_hi;
                    acc_next  = l_bits;
                end
                if (l_ascii || (l_bad && !fatal_reg)) begin
                    bom_next = 1'b1;
                end
            end else if (s_byte < lo_reg || s_byte > hi_reg) begin
                push         = 1'b1;
                push_job.cnt = 3'd1;
                push_job.err = 1'b1;
                need_next    = 2'd0;
                lo_next      = CONT_LO;
                hi_next      = CONT_HI;
                acc_next     = '0;
            end else begin
                lo_next   = CONT_LO;
                hi_next   = CONT_HI;
                acc_next  = cp;
                need_next = need_reg - 2'd1;
                if (need_reg == 2'd1) begin
                    acc_next = '0;
                    bom_next = 1'b1;
                    bom_drop = !bom_reg && cp == BOM_CP && !keep_bom_reg;
                    if (!bom_drop) begin
                        push = 1'b1;
                        priority if (cp < 21'h80) begin
                            push_job.bytes[0] = cp[7:0];
                            push_job.cnt      = 3'd1;
                        end else if (cp < 21'h800) begin
                            push_job.bytes[0] = {3'b110, cp[10:6]};
                            push_job.bytes[1] = {2'b10, cp[5:0]};
                            push_job.cnt      = 3'd2;
                        end else if (cp < 21'h10000) begin
                            push_job.bytes[0] = {4'b1110, cp[15:12]};
                            push_job.bytes[1] = {2'b10, cp[11:6]};
                            push_job.bytes[2] = {2'b10, cp[5:0]};
                            push_job.cnt      = 3'd3;
                        end else begin
                            push_job.bytes[0] = {5'b11110, cp[20:18]};
                            push_job.bytes[1] = {2'b10, cp[17:12]};
                            push_job.bytes[2] = {2'b10, cp[11:6]};
                            push_job.bytes[3] = {2'b10, cp[5:0]};
                            push_job.cnt      = 3'd4;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fatal_reg    <= 1'b0;
            keep_bom_reg <= 1'b0;
            need_reg     <= 2'd0;
            lo_reg       <= CONT_LO;
            hi_reg       <= CONT_HI;
            acc_reg      <= '0;
            bom_reg      <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == CFG_FATAL) begin
                fatal_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_KEEP_BOM) begin
                keep_bom_reg <= cfg_data;
            end
            need_reg <= need_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            acc_reg  <= acc_next;
            bom_reg  <= bom_next;
        end
    end

endmodule

/* rtl/u8rd_fifo.sv */
module u8rd_fifo import u8rd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic nonempty,
    output job_t head
);

    localparam int PW = $clog2(QDEPTH);

    job_t          mem_reg [QDEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;

    assign full     = (cnt_reg == (PW+1)'(QDEPTH));
    assign nonempty = (cnt_reg != '0);
    assign head     = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= (wp_reg == PW'(QDEPTH-1)) ? '0 : wp_reg + PW'(1);
            end
            if (pop) begin
                rp_reg <= (rp_reg == PW'(QDEPTH-1)) ? '0 : rp_reg + PW'(1);
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

/* rtl/u8rd_back.sv */
module u8rd_back import u8rd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       nonempty,
    input  job_t       head,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_byte,
    output logic       m_err,
    output logic       m_last
);

    logic [2:0] idx_reg, idx_next;
    logic       fire;

    assign m_valid = nonempty;
    assign m_byte  = head.bytes[idx_reg];
    assign m_err   = head.err;
    assign m_last  = (idx_reg == head.cnt - 3'd1);
    assign fire    = m_valid && m_ready;
    assign pop     = fire && m_last;

    always_comb begin
        idx_next = idx_reg;
        if (fire) begin
            idx_next = m_last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 3'd0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule

/* rtl/utf8_replacing_decoder.sv */
// Channel   | Dir | tdata            | tuser   | tlast
// s_axis    | in  | [7:0] data_byte  | kind    | -
// m_axis    | out | [7:0] out_byte   | error   | last
// cfg       | in  | cfg_data, index 0 fatal_mode, 1 BOM pass-through (cfg_we strobe)
//
// Input: one transaction per cycle while the two-entry burst queue has a free entry.
// Output: one result byte per cycle while m_axis_tready is high; an input transaction
// queues a burst of 0 to 6 bytes, registered in the burst queue until the output takes it.
// Hold s_axis_tready low while both queue entries hold bursts, even for items with no result.
// Reset (aresetn low, synchronous) clears decoder state, queue and registers.
module utf8_replacing_decoder import u8rd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic       cfg_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] kind
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] error
    output logic       m_axis_tlast
);

    logic push, pop, full, nonempty;
    job_t push_job, head;

    u8rd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_kind    (s_axis_tuser),
        .s_byte    (s_axis_tdata),
        .q_full    (full),
        .push      (push),
        .push_job  (push_job)
    );

    u8rd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (full),
        .nonempty (nonempty),
        .head     (head)
    );

    u8rd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .nonempty (nonempty),
        .head     (head),
        .pop      (pop),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_byte   (m_axis_tdata),
        .m_err    (m_axis_tuser),
        .m_last   (m_axis_tlast)
    );

endmodule

/* rtl/u8rd_checker.sv */
`include "utf8_replacing_decoder_defines.svh"

module u8rd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);

    // an error result stands alone and carries no byte
    `U8RD_ASSERT_IMP(a_err_last, aclk, aresetn, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
    `U8RD_ASSERT_IMP(a_err_zero, aclk, aresetn, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 8'd0)
    // hold a stalled result
    `U8RD_ASSERT_NXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    // drop all pending results on reset
    `U8RD_ASSERT_RST(a_rst, aclk, !aresetn, !m_axis_tvalid)

endmodule

bind utf8_replacing_decoder u8rd_checker u_u8rd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

/* test/tb.sv */
`timescale 1ns / 100ps

module tb import u8rd_pkg::*; ();

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 55;
    localparam int PLAN_ROWS   = 32;

    typedef struct packed {
        logic [7:0] value;
        logic       err;
        logic       last;
    } out_byte_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_op_e;

    typedef struct packed {
        row_op_e         op;
        logic            sel;
        logic [7:0]      data;
        logic            typed;
        logic [1:0]      n_due;
        logic [0:2][7:0] due;
        logic            due_err;
    } row_t;

    logic       aclk;
    logic       aresetn       = 1'b0;
    logic       cfg_we        = 1'b0;
    logic       cfg_index     = 1'b0;
    logic       cfg_data      = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tuser  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tuser;
    logic       m_axis_tlast;

    utf8_replacing_decoder i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // decoder shadow state and registers
    logic [1:0]  cont_left;
    logic [7:0]  cont_lo;
    logic [7:0]  cont_hi;
    logic [20:0] cp_acc;
    logic        bom_flag;
    logic        fatal_on;
    logic        bom_kept;

    out_byte_t   burst[$];
    out_byte_t   out_bytes_due[$];
    row_t        cur_row = '0;

    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          items_sent     = 0;
    int          failures       = 0;
    int          cycle_count    = 0;

    row_t plan [PLAN_ROWS] = '{
        '{ROW_ITEM, KIND_DATA, 8'h00, 1'b1, 2'd1, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'h7F, 1'b1, 2'd1, {8'h7F, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'h80, 1'b1, 2'd3, {RPL_B0, RPL_B1, RPL_B2}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'hFF, 1'b1, 2'd3, {RPL_B0, RPL_B1, RPL_B2}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'hC2, 1'b1, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'h80, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_END,  8'hFF, 1'b1, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'hEF, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'hBB, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'hBF, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'hE0, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'h9F, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'hED, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'hA0, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'hF0, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'h8F, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'hF4, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'h90, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'hF1, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_END,  8'h00, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_CFG,  CFG_FATAL, 8'h01, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'h80, 1'b1, 2'd1, {8'h00, 8'h00, 8'h00}, 1'b1},
        '{ROW_ITEM, KIND_DATA, 8'hC2, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'h41, 1'b1, 2'd1, {8'h00, 8'h00, 8'h00}, 1'b1},
        '{ROW_ITEM, KIND_DATA, 8'hE0, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_END,  8'h55, 1'b1, 2'd1, {8'h00, 8'h00, 8'h00}, 1'b1},
        '{ROW_CFG,  CFG_KEEP_BOM, 8'h01, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'hEF, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'hBB, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_ITEM, KIND_DATA, 8'hBF, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_CFG,  CFG_FATAL, 8'h00, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0},
        '{ROW_CFG,  CFG_KEEP_BOM, 8'h00, 1'b0, 2'd0, {8'h00, 8'h00, 8'h00}, 1'b0}
    };

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic void encode_cp(input logic [20:0] cp, output logic [0:3][7:0] enc,
                                      output int len);
        enc = '0;
        if (cp < 21'h80) begin
            enc[0] = cp[7:0];
            len = 1;
        end else if (cp < 21'h800) begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
            len = 2;
        end else if (cp < 21'h10000) begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
            len = 3;
        end else begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
            len = 4;
        end
    endfunction

    function automatic logic [20:0] pick_code_point(input int lo_class);
        case ($urandom_range(lo_class, 3))
            0: return 21'($urandom_range(0, 'h7F));
            1: return 21'($urandom_range('h80, 'h7FF));
            2: return 21'($urandom_range('h800, 'hFFFF));
            default: begin
                if ($urandom_range(0, 15) == 0)
                    return 21'($urandom_range('h110000, 'h13FFFF));
                return 21'($urandom_range('h10000, 'h10FFFF));
            end
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] value, input logic err);
        out_byte_t ob;
        ob = '{value: value, err: err, last: 1'b0};
        burst.push_back(ob);
    endtask

    task automatic push_fffd();
        push_byte(RPL_B0, 1'b0);
        push_byte(RPL_B1, 1'b0);
        push_byte(RPL_B2, 1'b0);
    endtask

    task automatic clear_seq();
        cont_left = 2'd0;
        cont_lo   = CONT_LO;
        cont_hi   = CONT_HI;
        cp_acc    = '0;
    endtask

    task automatic start_seq(input logic [1:0] need, input logic [7:0] lo,
                             input logic [7:0] hi, input logic [20:0] bits);
        cont_left = need;
        cont_lo   = lo;
        cont_hi   = hi;
        cp_acc    = bits;
    endtask

    task automatic take_lead(input logic [7:0] b);
        if (b < 8'h80) begin
            bom_flag = 1'b1;
            push_byte(b, 1'b0);
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
            start_seq(2'd1, CONT_LO, CONT_HI, 21'(b[4:0]));
        end else if (b == 8'hE0) begin
            start_seq(2'd2, E0_LO, CONT_HI, 21'(b[3:0]));
        end else if (b == 8'hED) begin
            start_seq(2'd2, CONT_LO, ED_HI, 21'(b[3:0]));
        end else if (b >= 8'hE1 && b <= 8'hEF) begin
            start_seq(2'd2, CONT_LO, CONT_HI, 21'(b[3:0]));
        end else if (b == 8'hF0) begin
            start_seq(2'd3, F0_LO, CONT_HI, 21'(b[2:0]));
        end else if (b == 8'hF4) begin
            start_seq(2'd3, CONT_LO, F4_HI, 21'(b[2:0]));
        end else if (b >= 8'hF1 && b <= 8'hF3) begin
            start_seq(2'd3, CONT_LO, CONT_HI, 21'(b[2:0]));
        end else if (fatal_on) begin
            push_byte(8'h00, 1'b1);
        end else begin
            bom_flag = 1'b1;
            push_fffd();
        end
    endtask

    task automatic sanitize_item(input logic kind, input logic [7:0] b);
        logic [20:0]     cp;
        logic [0:3][7:0] enc;
        int              len;
        out_byte_t       tail;
        burst.delete();
        if (kind == KIND_END) begin
            if (cont_left != 2'd0) begin
                if (fatal_on)
                    push_byte(8'h00, 1'b1);
                else
                    push_fffd();
            end
            clear_seq();
            bom_flag = 1'b0;
        end else if (cont_left == 2'd0) begin
            take_lead(b);
        end else if (b < cont_lo || b > cont_hi) begin
            clear_seq();
            if (fatal_on) begin
                push_byte(8'h00, 1'b1);
            end else begin
                push_fffd();
                bom_flag = 1'b1;
                take_lead(b);
            end
        end else begin
            cont_lo   = CONT_LO;
            cont_hi   = CONT_HI;
            cp_acc    = {cp_acc[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                cp     = cp_acc;
                cp_acc = '0;
                if (!bom_flag && cp == BOM_CP && !bom_kept) begin
                    bom_flag = 1'b1;
                end else begin
                    bom_flag = 1'b1;
                    encode_cp(cp, enc, len);
                    for (int i = 0; i < len; i++)
                        push_byte(enc[i], 1'b0);
                end
            end
        end
        if (burst.size() > 0) begin
            tail = burst.pop_back();
            tail.last = 1'b1;
            burst.push_back(tail);
        end
    endtask

    // predict on input transactions, check on output transactions
    always @(negedge aclk) begin : monitor
        out_byte_t want;
        out_byte_t got;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            sanitize_item(s_axis_tuser, s_axis_tdata);
            if (cur_row.typed) begin
                for (int i = 0; i < cur_row.n_due; i++) begin
                    want = '{value: cur_row.due[i], err: cur_row.due_err,
                             last: (i == cur_row.n_due - 1)};
                    out_bytes_due.push_back(want);
                end
            end else begin
                foreach (burst[i])
                    out_bytes_due.push_back(burst[i]);
            end
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = '{value: m_axis_tdata, err: m_axis_tuser, last: m_axis_tlast};
            if (out_bytes_due.size() == 0) begin
                if (failures < 10)
                    $display("unexpected output byte %02h err %0b last %0b",
                             got.value, got.err, got.last);
                failures++;
            end else begin
                want = out_bytes_due.pop_front();
                if (got !== want) begin
                    if (failures < 10)
                        $display("mismatch: expected %02h err %0b last %0b, got %02h err %0b last %0b",
                                 want.value, want.err, want.last,
                                 got.value, got.err, got.last);
                    failures++;
                end
            end
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] data);
        logic taken;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= kind;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_axis_tready;
            @(posedge aclk);
        end
        items_sent++;
    endtask

    task automatic send_code_point(input logic [20:0] cp, input int drop);
        logic [0:3][7:0] enc;
        int              len;
        int              n;
        encode_cp(cp, enc, len);
        n = (len - drop < 1) ? 1 : len - drop;
        for (int i = 0; i < n; i++)
            send_item(KIND_DATA, enc[i]);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (out_bytes_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_FATAL)
            fatal_on = val;
        else
            bom_kept = val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin : stimulus
        int roll;
        int phase_end;
        fatal_on = 1'b0;
        bom_kept = 1'b0;
        bom_flag = 1'b0;
        clear_seq();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct   = 33;
        sink_stall_pct = 33;
        foreach (plan[i]) begin
            if (plan[i].op == ROW_CFG) begin
                drain();
                write_reg(plan[i].sel, plan[i].data[0]);
            end else begin
                cur_row = plan[i];
                send_item(plan[i].sel, plan[i].data);
            end
        end
        cur_row = '0;

        for (int p = 0; p < 4; p++) begin
            drain();
            write_reg(CFG_FATAL, p[0]);
            write_reg(CFG_KEEP_BOM, p[1]);
            case (p)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 62; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 62; end
                default: begin src_idle_pct = 33; sink_stall_pct = 33; end
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                roll = $urandom_range(0, 99);
                if (roll < 55) begin
                    send_code_point(pick_code_point(0), 0);
                end else if (roll < 62) begin
                    send_item(KIND_END, 8'($urandom));
                    send_code_point(BOM_CP, 0);
                end else if (roll < 72) begin
                    send_code_point(pick_code_point(1), $urandom_range(1, 3));
                    send_item(1'($urandom_range(0, 1)), 8'($urandom));
                end else if (roll < 85) begin
                    send_item(KIND_DATA, 8'($urandom));
                end else if (roll < 93) begin
                    send_item(KIND_DATA, 8'($urandom_range('hC2, 'hF4)));
                    send_item(KIND_DATA, 8'($urandom));
                end else begin
                    send_item(KIND_END, 8'($urandom));
                end
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/u8rd_pkg.sv
rtl/u8rd_front.sv
rtl/u8rd_fifo.sv
rtl/u8rd_back.sv
rtl/utf8_replacing_decoder.sv
rtl/u8rd_checker.sv
test/tb.sv
